// ===== rtl/top4_weight_selector_assert.svh =====
// Assertion macros used by the verification checker of the top-4 weight selector.
`ifndef TOP4_WEIGHT_SELECTOR_ASSERT_SVH
`define TOP4_WEIGHT_SELECTOR_ASSERT_SVH

// A property checked on every clock edge once reset is released.
`define T4WS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked on every clock edge, reset included.
`define T4WS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/t4ws_pkg.sv =====
// Package with the widths, constants and types of the top-4 weight selector.
package t4ws_pkg;

    localparam int SLOT_COUNT_DEF = 4;
    localparam int OUT_PAIRS      = 4;
    localparam int MAX_BONES      = 64;

    localparam int IDX_W    = 6;
    localparam int BONE_W   = 7;
    localparam int WEIGHT_W = 17;
    localparam int PAIR_W   = BONE_W + WEIGHT_W;
    localparam int IN_W     = 24;
    localparam int OUT_W    = OUT_PAIRS * PAIR_W;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [BONE_W-1:0]   t_bone;
    typedef logic [WEIGHT_W-1:0] t_weight;

    localparam t_bone   EMPTY_BONE = 7'h7F;
    localparam t_weight WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        t_bone   bone;
        t_weight weight;
    } t_pair;

    localparam t_pair EMPTY_PAIR = '{bone: EMPTY_BONE, weight: '0};

    typedef struct packed {
        logic load;
        logic flush;
    } t_slot_cmd;

endpackage

// ===== rtl/t4ws_slots.sv =====
// Sorted slot registers with the insertion and clear logic.
module t4ws_slots #(
    parameter int SLOT_COUNT = t4ws_pkg::SLOT_COUNT_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t4ws_pkg::t_slot_cmd                       i_cmd,
    input  t4ws_pkg::t_idx                            i_bone,
    input  t4ws_pkg::t_weight                         i_weight,
    output t4ws_pkg::t_pair [t4ws_pkg::OUT_PAIRS-1:0] o_pairs
);
    import t4ws_pkg::*;

    t_pair   r_slot  [SLOT_COUNT];
    t_pair   n_slot  [SLOT_COUNT];
    t_pair   shifted [SLOT_COUNT];
    t_pair   item;
    t_weight w_sat;
    logic    in_range;

    assign w_sat    = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
    assign in_range = int'(i_bone) < MAX_BONES;
    assign item     = '{bone: {1'b0, i_bone}, weight: w_sat};

    assign shifted[0] = item;
    for (genvar g = 1; g < SLOT_COUNT; g++) begin : g_shift
        assign shifted[g] = r_slot[g-1];
    end

    always_comb begin
        logic seen;
        logic lt;
        seen = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            lt = in_range && (r_slot[i].weight < w_sat);
            if (seen) begin
                n_slot[i] = shifted[i];
            end else if (lt) begin
                n_slot[i] = item;
            end else begin
                n_slot[i] = r_slot[i];
            end
            seen = seen | lt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!i_rst_n || (i_cmd.load && i_cmd.flush)) begin
                r_slot[i] <= EMPTY_PAIR;
            end else if (i_cmd.load) begin
                r_slot[i] <= n_slot[i];
            end
        end
    end

    for (genvar k = 0; k < OUT_PAIRS; k++) begin : g_out
        if (k < SLOT_COUNT) begin : g_used
            assign o_pairs[k] = n_slot[k];
        end else begin : g_empty
            assign o_pairs[k] = EMPTY_PAIR;
        end
    end

endmodule

// ===== rtl/top4_weight_selector.sv =====
// Top level of the top-4 weight selector with its stream handshakes and registers.
//
// Channel   Dir  Transaction               Payload
// s_axis    in   one (bone, weight) pair   tdata, tlast marks the vertex's last pair
// m_axis    out  one vertex result         tdata with four (bone, weight) pairs
//
// One pair is taken every cycle unless a last pair waits on a stalled result.
// A result is registered when a vertex's last pair leaves the input register.
// A stalled result only holds back a last pair; other pairs keep flowing.
// Reset clears the slots to empty and drops both valid flags.
module top4_weight_selector #(
    parameter int SLOT_COUNT = t4ws_pkg::SLOT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [5:0] bone_index, [22:6] weight, [23] zero
    input  logic [t4ws_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [6:0] first_bone, [23:7] first_weight, [30:24] second_bone,
    // [47:31] second_weight, [54:48] third_bone, [71:55] third_weight,
    // [78:72] fourth_bone, [95:79] fourth_weight
    output logic [t4ws_pkg::OUT_W-1:0]  m_axis_tdata
);
    import t4ws_pkg::*;

    logic                  r_in_valid;
    logic                  r_in_last;
    t_idx                  r_in_bone;
    t_weight               r_in_weight;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic [OUT_W-1:0]      n_out_data;
    logic                  out_free;
    logic                  in_go;
    logic                  accept;
    t_slot_cmd             cmd;
    t_pair [OUT_PAIRS-1:0] pairs;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_go         = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || in_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cmd.load  = in_go;
    assign cmd.flush = r_in_last;

    t4ws_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_bone   (r_in_bone),
        .i_weight (r_in_weight),
        .o_pairs  (pairs)
    );

    always_comb begin
        for (int k = 0; k < OUT_PAIRS; k++) begin
            n_out_data[k*PAIR_W +: BONE_W]            = pairs[k].bone;
            n_out_data[k*PAIR_W + BONE_W +: WEIGHT_W] = pairs[k].weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (in_go) begin
                r_in_valid <= 1'b0;
            end
            if (in_go && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_bone   <= s_axis_tdata[IDX_W-1:0];
            r_in_weight <= s_axis_tdata[IDX_W +: WEIGHT_W];
            r_in_last   <= s_axis_tlast;
        end
        if (in_go && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/t4ws_checker.sv =====
// Port-level assertion checker for the top-4 weight selector and its bind.
`include "top4_weight_selector_assert.svh"

module t4ws_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [t4ws_pkg::OUT_W-1:0] m_axis_tdata
);
    import t4ws_pkg::*;

    t_bone   b0, b1, b2, b3;
    t_weight w0, w1, w2, w3;
    logic    sorted;
    logic    bounded;
    logic    empty_match;

    assign b0 = m_axis_tdata[0*PAIR_W +: BONE_W];
    assign b1 = m_axis_tdata[1*PAIR_W +: BONE_W];
    assign b2 = m_axis_tdata[2*PAIR_W +: BONE_W];
    assign b3 = m_axis_tdata[3*PAIR_W +: BONE_W];
    assign w0 = m_axis_tdata[0*PAIR_W + BONE_W +: WEIGHT_W];
    assign w1 = m_axis_tdata[1*PAIR_W + BONE_W +: WEIGHT_W];
    assign w2 = m_axis_tdata[2*PAIR_W + BONE_W +: WEIGHT_W];
    assign w3 = m_axis_tdata[3*PAIR_W + BONE_W +: WEIGHT_W];

    assign sorted      = (w0 >= w1) && (w1 >= w2) && (w2 >= w3);
    assign bounded     = (w0 <= WEIGHT_ONE);
    assign empty_match = ((b0 == EMPTY_BONE) == (w0 == '0))
                      && ((b1 == EMPTY_BONE) == (w1 == '0))
                      && ((b2 == EMPTY_BONE) == (w2 == '0))
                      && ((b3 == EMPTY_BONE) == (w3 == '0));

    `T4WS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `T4WS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `T4WS_ASSERT(a_sorted, i_clk, i_rst_n, m_axis_tvalid |-> sorted && bounded, "result weights not descending or above one")
    `T4WS_ASSERT(a_empty, i_clk, i_rst_n, m_axis_tvalid |-> empty_match, "empty bone and zero weight disagree")

endmodule

bind top4_weight_selector t4ws_checker u_t4ws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
